### rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/lcbs_pkg.sv
package lcbs_pkg;

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int ROM_AW    = 14;
  localparam int RAM_DEPTH = 16384;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int NUM_FLAGS = 4;

  // mode flag bit positions
  localparam int FLAG_RAM   = 0;
  localparam int FLAG_WRITE = 1;
  localparam int FLAG_RAM2  = 2;
  localparam int FLAG_ALTZP = 3;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [ADDR_W-1:0] BANK_BASE   = 16'hD000;
  localparam logic [ADDR_W-1:0] BANK2_LIMIT = 16'hE000;
  localparam logic [ADDR_W-1:0] SWITCH_BASE = 16'hC080;
  localparam logic [ADDR_W-1:0] STAT_RAM2   = 16'hC011;
  localparam logic [ADDR_W-1:0] STAT_RAM    = 16'hC012;
  localparam logic [ADDR_W-1:0] STAT_ALTZP  = 16'hC016;
  localparam logic [ADDR_W-1:0] ALTZP_OFF   = 16'hC008;
  localparam logic [ADDR_W-1:0] ALTZP_ON    = 16'hC009;

  localparam logic [RAM_AW-1:0] BANK2_SHIFT = 14'h3000;
  localparam logic [DATA_W-1:0] STATUS_SET  = 8'h80;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] idx;
    logic [DATA_W-1:0] wdata;
  } ram_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] fixed_data;
    logic              use_ram;
    logic              rom_sel;
    logic [ROM_AW-1:0] rom_addr;
    logic              handled;
  } rsp_info_t;

endpackage

### rtl/core/lcbs_req_if.sv
interface lcbs_req_if;
  import lcbs_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output action, output address, output write_data,
                  input ready);
  modport sink (input valid, input action, input address, input write_data,
                output ready);
endinterface

### rtl/core/lcbs_rsp_if.sv
interface lcbs_rsp_if;
  import lcbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              rom_selected;
  logic [ROM_AW-1:0] rom_address;
  logic              handled;

  modport source (output valid, output read_data, output rom_selected,
                  output rom_address, output handled, input ready);
  modport sink (input valid, input read_data, input rom_selected,
                input rom_address, input handled, output ready);
endinterface

### rtl/core/lcbs_ram.sv
module lcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lcbs_clear.sv
module lcbs_clear
  import lcbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  output logic              busy,
  output logic [RAM_AW-1:0] addr
);

  // one RAM entry zeroed per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      addr <= addr + 1'b1;
      if (addr == RAM_AW'(RAM_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/lcbs_decode.sv
module lcbs_decode
  import lcbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              action,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  output ram_cmd_t          ram_cmd,
  output rsp_info_t         info
);

  logic [NUM_FLAGS-1:0] flags;
  logic [NUM_FLAGS-1:0] flags_next;
  logic [ADDR_W-1:0]    offset;
  logic [RAM_AW-1:0]    ram_idx;
  logic                 is_write;
  logic                 is_switch;
  logic                 sel_ram;
  logic                 sel_write;

  assign is_write  = (action == ACT_WRITE);
  assign offset    = address - BANK_BASE;
  assign ram_idx   = offset[RAM_AW-1:0] +
                     (((address < BANK2_LIMIT) && flags[FLAG_RAM2]) ? BANK2_SHIFT : '0);
  assign is_switch = (address[ADDR_W-1:4] == SWITCH_BASE[ADDR_W-1:4]) && !address[2];

  // low two address bits pick read-RAM / write-enable
  always_comb begin
    unique case (address[1:0])
      2'd0:    begin sel_ram = 1'b1; sel_write = 1'b0; end
      2'd1:    begin sel_ram = 1'b0; sel_write = 1'b1; end
      2'd2:    begin sel_ram = 1'b0; sel_write = 1'b0; end
      default: begin sel_ram = 1'b1; sel_write = 1'b1; end
    endcase
  end

  always_comb begin
    flags_next    = flags;
    ram_cmd.we    = 1'b0;
    ram_cmd.idx   = ram_idx;
    ram_cmd.wdata = write_data;
    info          = '0;
    priority if (address >= BANK_BASE) begin
      info.handled = 1'b1;
      if (is_write) begin
        ram_cmd.we = flags[FLAG_WRITE];
      end else if (!flags[FLAG_RAM]) begin
        info.rom_sel  = 1'b1;
        info.rom_addr = offset[ROM_AW-1:0];
      end else begin
        info.use_ram = 1'b1;
      end
    end else if (is_write) begin
      if (address == ALTZP_OFF) begin
        info.handled          = 1'b1;
        flags_next[FLAG_ALTZP] = 1'b0;
      end else if (address == ALTZP_ON) begin
        info.handled          = 1'b1;
        flags_next[FLAG_ALTZP] = 1'b1;
      end
    end else if (is_switch) begin
      info.handled           = 1'b1;
      info.fixed_data        = STATUS_SET;
      flags_next[FLAG_RAM]   = sel_ram;
      flags_next[FLAG_WRITE] = sel_write;
      flags_next[FLAG_RAM2]  = !address[3];
    end else if (address == STAT_RAM2) begin
      info.handled    = 1'b1;
      info.fixed_data = flags[FLAG_RAM2] ? STATUS_SET : '0;
    end else if (address == STAT_RAM) begin
      info.handled    = 1'b1;
      info.fixed_data = flags[FLAG_RAM] ? STATUS_SET : '0;
    end else if (address == STAT_ALTZP) begin
      info.handled    = 1'b1;
      info.fixed_data = flags[FLAG_ALTZP] ? STATUS_SET : '0;
    end else begin
      // any other read: not handled, all result fields stay zero
      info.handled = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (accept) begin
      flags <= flags_next;
    end
  end

endmodule

### rtl/core/language_card_bank_switch_top.sv
// Language card bank switching for the $D000-$FFFF region of a byte bus.
// req channel (valid/ready): one bus access per transaction: action
// (0 read, 1 write), 16-bit address, write byte.
// rsp channel (valid/ready): exactly one result per access: read_data,
// rom_selected, rom_address (offset from $D000), handled.
// Pipeline: when an access is taken it is decoded and the RAM port read;
// the decode result and RAM read data are held in the middle stage, then
// merged into the output register that offers the result on rsp. One access
// per cycle is sustained while rsp keeps taking results.
// Mode flags update when an access is taken, so the next access sees them.
// Reset: flags clear to ROM read / write off, then a clearing pass zeroes
// the 16384-byte RAM one byte per cycle; req.ready stays low for the whole
// clearing pass.
// Stall: if rsp is not taken, one more access can be held in the middle
// stage; after that req.ready drops until the output register drains.
`include "assert_macros.svh"

module language_card_bank_switch_top
  import lcbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lcbs_req_if.sink   req,
  lcbs_rsp_if.source rsp
);

  ram_cmd_t          ram_cmd;
  rsp_info_t         info;
  rsp_info_t         s1_info;
  logic              s1_valid;
  logic              s1_adv;
  logic              accept;
  logic              clr_busy;
  logic [RAM_AW-1:0] clr_addr;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  logic              out_rom_sel;
  logic [ROM_AW-1:0] out_rom_addr;
  logic              out_handled;

  assign s1_adv    = !out_valid || rsp.ready;
  assign req.ready = !clr_busy && (!s1_valid || s1_adv);
  assign accept    = req.valid && req.ready;

  lcbs_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (req.action),
    .address    (req.address),
    .write_data (req.write_data),
    .ram_cmd    (ram_cmd),
    .info       (info)
  );

  lcbs_clear u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  assign ram_we    = clr_busy ? 1'b1     : (accept && ram_cmd.we);
  assign ram_waddr = clr_busy ? clr_addr : ram_cmd.idx;
  assign ram_wdata = clr_busy ? '0       : ram_cmd.wdata;

  // read data register holds while the middle stage is stalled
  lcbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_cmd.idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
    if (s1_adv && s1_valid) begin
      out_data     <= s1_info.use_ram ? ram_rdata : s1_info.fixed_data;
      out_rom_sel  <= s1_info.rom_sel;
      out_rom_addr <= s1_info.rom_addr;
      out_handled  <= s1_info.handled;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_data;
  assign rsp.rom_selected = out_rom_sel;
  assign rsp.rom_address  = out_rom_addr;
  assign rsp.handled      = out_handled;

  `ASSERT_IMPLIES(a_no_accept_clearing, clk, rst, clr_busy, !req.ready)
  `ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_info))
  `ASSERT_IMPLIES(a_rom_result, clk, rst, rsp.valid && rsp.rom_selected, rsp.handled && (rsp.read_data == '0))
  `ASSERT_IMPLIES(a_unhandled_zero, clk, rst, rsp.valid && !rsp.handled, !rsp.rom_selected && (rsp.read_data == '0) && (rsp.rom_address == '0))

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lcbs_pkg::*;

  // soft switch addresses used by the directed tests
  localparam logic [ADDR_W-1:0] SW_B2_RAM_RD = SWITCH_BASE + 16'h0;
  localparam logic [ADDR_W-1:0] SW_B2_ROM_WE = SWITCH_BASE + 16'h1;
  localparam logic [ADDR_W-1:0] SW_B2_ROM    = SWITCH_BASE + 16'h2;
  localparam logic [ADDR_W-1:0] SW_B2_RAM_WE = SWITCH_BASE + 16'h3;
  localparam logic [ADDR_W-1:0] SW_B2_HOLE   = SWITCH_BASE + 16'h4;
  localparam logic [ADDR_W-1:0] SW_B1_RAM_RD = SWITCH_BASE + 16'h8;
  localparam logic [ADDR_W-1:0] SW_B1_RAM_WE = SWITCH_BASE + 16'hB;
  localparam logic [ADDR_W-1:0] SW_B1_HOLE   = SWITCH_BASE + 16'hF;
  localparam logic [ADDR_W-1:0] BANK_TOP     = 16'hFFFF;

  localparam int RANDOM_ACCESSES = 850;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              rom_selected;
    logic [ROM_AW-1:0] rom_address;
    logic              handled;
  } access_result_t;

  logic clk;
  logic rst = 1'b1;

  lcbs_req_if req_bus ();
  lcbs_rsp_if rsp_bus ();

  language_card_bank_switch_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // shadow copy of the card state
  bit [NUM_FLAGS-1:0] card_flags;
  bit [DATA_W-1:0]    card_ram [RAM_DEPTH];

  access_result_t expected_results[$];
  int error_count;
  int items_sent;
  bit bus_quiet;
  bit drain_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [RAM_AW-1:0] card_offset(logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] off;
    off = addr - BANK_BASE;
    if (addr < BANK2_LIMIT && card_flags[FLAG_RAM2]) off = off + ADDR_W'(BANK2_SHIFT);
    return off[RAM_AW-1:0];
  endfunction

  // applies one access to the shadow state and returns the result it yields
  function automatic access_result_t apply_access(logic act, logic [ADDR_W-1:0] addr,
                                                  logic [DATA_W-1:0] wdata);
    access_result_t r;
    logic [3:0] low;
    logic [NUM_FLAGS-1:0] m;
    r = '0;
    low = addr[3:0];
    if (addr >= BANK_BASE) begin
      r.handled = 1'b1;
      if (act == ACT_WRITE) begin
        if (card_flags[FLAG_WRITE]) card_ram[card_offset(addr)] = wdata;
      end else if (!card_flags[FLAG_RAM]) begin
        r.rom_selected = 1'b1;
        r.rom_address = ROM_AW'(addr - BANK_BASE);
      end else begin
        r.read_data = card_ram[card_offset(addr)];
      end
    end else if (act == ACT_WRITE) begin
      if (addr == ALTZP_OFF) begin
        r.handled = 1'b1;
        card_flags[FLAG_ALTZP] = 1'b0;
      end else if (addr == ALTZP_ON) begin
        r.handled = 1'b1;
        card_flags[FLAG_ALTZP] = 1'b1;
      end
    end else if (addr[ADDR_W-1:4] == SWITCH_BASE[ADDR_W-1:4] && !low[2]) begin
      // low two bits: 0 RAM read, 1 write only, 2 ROM, 3 RAM read + write
      m = '0;
      m[FLAG_RAM]   = (low[1:0] == 2'd0) || (low[1:0] == 2'd3);
      m[FLAG_WRITE] = low[0];
      m[FLAG_RAM2]  = !low[3];
      m[FLAG_ALTZP] = card_flags[FLAG_ALTZP];
      card_flags = m;
      r.handled = 1'b1;
      r.read_data = STATUS_SET;
    end else if (addr == STAT_RAM2) begin
      r.handled = 1'b1;
      r.read_data = card_flags[FLAG_RAM2] ? STATUS_SET : '0;
    end else if (addr == STAT_RAM) begin
      r.handled = 1'b1;
      r.read_data = card_flags[FLAG_RAM] ? STATUS_SET : '0;
    end else if (addr == STAT_ALTZP) begin
      r.handled = 1'b1;
      r.read_data = card_flags[FLAG_ALTZP] ? STATUS_SET : '0;
    end
    return r;
  endfunction

  task automatic send_access(input logic act, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    int gap;
    access_result_t r;
    gap = draw_wait(bus_quiet);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.action     <= act;
    req_bus.address    <= addr;
    req_bus.write_data <= wdata;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    r = apply_access(act, addr, wdata);
    items_sent++;
    expected_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // response side: random stalls, every transaction checked in order
  initial begin
    int gap;
    access_result_t want;
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_wait(drain_quiet);
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (rsp_bus.valid !== 1'b1);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0h/%0b/%0h/%0b", $time,
                 rsp_bus.read_data, rsp_bus.rom_selected, rsp_bus.rom_address,
                 rsp_bus.handled);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("read_data", 16'(want.read_data), 16'(rsp_bus.read_data));
        compare_field("rom_selected", 16'(want.rom_selected), 16'(rsp_bus.rom_selected));
        compare_field("rom_address", 16'(want.rom_address), 16'(rsp_bus.rom_address));
        compare_field("handled", 16'(want.handled), 16'(rsp_bus.handled));
      end
    end
  end

  task automatic test_power_on;
    send_access(ACT_READ, BANK_BASE, 8'h00);
    send_access(ACT_READ, BANK_TOP, 8'h00);
    send_access(ACT_WRITE, BANK_BASE, 8'hFF);   // write off: dropped
    send_access(ACT_READ, STAT_RAM2, 8'h00);
    send_access(ACT_READ, STAT_RAM, 8'h00);
    send_access(ACT_READ, STAT_ALTZP, 8'h00);
  endtask

  task automatic test_switches;
    send_access(ACT_READ, SW_B2_ROM_WE, 8'h00);
    send_access(ACT_READ, SW_B2_HOLE, 8'h00);
    send_access(ACT_WRITE, SW_B2_RAM_RD, 8'hA5);   // switch writes are ignored
    send_access(ACT_WRITE, ALTZP_ON, 8'h00);
    send_access(ACT_READ, STAT_ALTZP, 8'h00);
    send_access(ACT_READ, ALTZP_ON, 8'h00);
    send_access(ACT_READ, SW_B1_RAM_RD, 8'h00);    // alt zero page must survive
    send_access(ACT_READ, STAT_ALTZP, 8'h00);
    send_access(ACT_READ, STAT_RAM, 8'h00);
    send_access(ACT_READ, STAT_RAM2, 8'h00);
    send_access(ACT_WRITE, ALTZP_OFF, 8'hFF);
    send_access(ACT_READ, SW_B1_HOLE, 8'h00);
    send_access(ACT_READ, 16'h0000, 8'h00);
  endtask

  task automatic test_bank_ram;
    send_access(ACT_READ, SW_B2_RAM_WE, 8'h00);
    send_access(ACT_WRITE, BANK_BASE, 8'hFF);
    send_access(ACT_WRITE, BANK2_LIMIT - 16'd1, 8'h01);
    send_access(ACT_WRITE, BANK2_LIMIT, 8'h80);
    send_access(ACT_READ, BANK_BASE, 8'h00);
    send_access(ACT_READ, SW_B1_RAM_WE, 8'h00);
    send_access(ACT_READ, BANK_BASE, 8'h00);        // bank 1 still clear
    send_access(ACT_WRITE, BANK_TOP, 8'h7E);
    send_access(ACT_READ, BANK_TOP, 8'h00);
    send_access(ACT_READ, BANK2_LIMIT, 8'h00);
    send_access(ACT_READ, SW_B2_ROM, 8'h00);
    send_access(ACT_WRITE, BANK2_LIMIT, 8'h55);     // write off again
  endtask

  function automatic logic [ADDR_W-1:0] pick_bank_addr();
    case ($urandom_range(0, 4))
      0: return BANK_BASE + ADDR_W'($urandom_range(0, 15));
      1: return BANK2_LIMIT - 16'd16 + ADDR_W'($urandom_range(0, 31));
      2: return BANK_TOP - ADDR_W'($urandom_range(0, 15));
      default: return ADDR_W'($urandom_range(BANK_BASE, BANK_TOP));
    endcase
  endfunction

  // mode switch followed by a run of bank accesses, with some noise mixed in
  task automatic test_random_traffic;
    int n;
    logic [ADDR_W-1:0] a;
    while (items_sent < RANDOM_ACCESSES) begin
      send_access(ACT_READ, SWITCH_BASE + ADDR_W'($urandom_range(0, 15)), 8'h00);
      n = $urandom_range(2, 8);
      repeat (n) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            case ($urandom_range(0, 2))
              0: a = STAT_RAM2;
              1: a = STAT_RAM;
              default: a = STAT_ALTZP;
            endcase
            send_access(ACT_READ, a, DATA_W'($urandom));
          end
          2: send_access(ACT_WRITE, $urandom_range(0, 1) ? ALTZP_ON : ALTZP_OFF,
                         DATA_W'($urandom));
          3: send_access(ACT_READ, $urandom_range(0, 1) ? ALTZP_ON : ALTZP_OFF, 8'h00);
          4, 5: send_access(1'($urandom), ADDR_W'($urandom), DATA_W'($urandom));
          default: send_access(1'($urandom), pick_bank_addr(), DATA_W'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    req_bus.valid      <= 1'b0;
    req_bus.action     <= ACT_READ;
    req_bus.address    <= '0;
    req_bus.write_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_power_on();
    test_switches();
    test_bank_ram();
    test_random_traffic();
    req_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/lcbs_pkg.sv
rtl/core/lcbs_req_if.sv
rtl/core/lcbs_rsp_if.sv
rtl/core/lcbs_ram.sv
rtl/core/lcbs_clear.sv
rtl/core/lcbs_decode.sv
rtl/core/language_card_bank_switch_top.sv
tb/sv/tb_top.sv
